FILE: hdl/ept_pkg.sv
package ept_pkg;

  localparam int CNT_W = 32;
  localparam int POS_W = 48;
  localparam int VEL_FRAC = 16;
  localparam int VEL_QBITS = 47;
  localparam int DABS_W = 35;
  localparam int MUL_A_W = 35;
  localparam int MUL_B_W = 32;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam logic signed [POS_W-1:0] POS_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [POS_W-1:0] NEG_MIN = 48'sh8000_0000_0000;

  localparam logic [CNT_W-1:0] TOP_DEFAULT = 32'd65535;
  localparam logic [CNT_W-1:0] CLOCK_DEFAULT = 32'd180000000;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_SET_POS = 1'b1;

  typedef enum logic [1:0] {
    REG_COUNTER_TOP = 2'd0,
    REG_INVERT      = 2'd1,
    REG_CLOCK_HZ    = 2'd2,
    REG_LPF_TAU     = 2'd3
  } cfg_reg_t;

endpackage

FILE: hdl/ept_div_step.sv
module ept_div_step
  import ept_pkg::*;
(
  input  logic [CNT_W-1:0] rem,
  input  logic             bit_in,
  input  logic [CNT_W-1:0] divisor,
  output logic [CNT_W-1:0] rem_next,
  output logic             q_bit
);

  logic [CNT_W+1:0] trial;

  // restoring step, rem is always below divisor
  assign trial = {1'b0, rem, bit_in} - {2'b00, divisor};
  assign q_bit = ~trial[CNT_W+1];
  assign rem_next = q_bit ? trial[CNT_W-1:0] : {rem[CNT_W-2:0], bit_in};

endmodule

FILE: hdl/ept_mul.sv
module ept_mul
  import ept_pkg::*;
(
  input  logic               clk,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output logic [MUL_P_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= {{MUL_B_W{1'b0}}, a} * {{MUL_A_W{1'b0}}, b};
  end

endmodule

FILE: hdl/encoder_position_velocity_tracker_unit.sv
// result word path: set position or zero elapsed go from accept straight to the output stage;
// a sample without filter runs delta, fold, invert, position, velocity multiply and the velocity
// divide on the shared divide step; with filter the gain divide reuses the step
// occupancy: one word in flight, the next word can be taken in the cycle after the result is
// registered and then waits for the output register if the previous word is still stalled
// synchronous reset clears position, velocities, previous count and loads register defaults
module encoder_position_velocity_tracker_unit
  import ept_pkg::*;
#(
  parameter int FILTER_GAIN_FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [CNT_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    cmd,
  input  logic [CNT_W-1:0]        raw_count,
  input  logic [CNT_W-1:0]        elapsed_cycles,
  input  logic signed [POS_W-1:0] new_position,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [POS_W-1:0] position_counts,
  output logic signed [POS_W-1:0] velocity_cps,
  output logic                    sample_taken
);

  localparam int F = FILTER_GAIN_FRAC_BITS;
  localparam int SHL = 24 - F;
  localparam int ITER_W = 6;

  typedef enum logic [4:0] {
    S_IDLE, S_DELTA, S_FOLD_HI, S_FOLD_LO, S_INV, S_POS, S_DPOS, S_VMUL, S_VCHK,
    S_VDIV, S_VSIGN, S_FCHK, S_KDIV, S_FDIFF, S_FMUL_HI, S_FMUL_LO, S_FSUM, S_DONE
  } state_t;

  state_t state;

  logic [CNT_W-1:0] counter_top, clock_hz, lpf_tau;
  logic invert;

  logic [CNT_W-1:0] previous_count;
  logic signed [POS_W-1:0] position, filtered_velocity, current_velocity;

  logic [CNT_W-1:0] raw_r, el_r;
  logic taken;
  logic signed [DABS_W-1:0] d;
  logic signed [POS_W-1:0] pos_old;
  logic dneg;
  logic [DABS_W-1:0] dabs;
  logic vsat;
  logic [CNT_W-1:0] r;
  logic [VEL_QBITS-1:0] nlow, q;
  logic [ITER_W-1:0] iter;
  logic signed [POS_W-1:0] vraw;
  logic fneg;
  logic [POS_W:0] fabs, acc;

  logic [CNT_W-1:0] top;
  logic [CNT_W:0] modv;
  logic [CNT_W-1:0] half;
  logic signed [POS_W:0] sum, dpos, fdiff;
  logic [POS_W:0] step;
  logic [MUL_P_W-1:0] prod, prod_shl, prod_shr;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic div_bit, div_q;
  logic [CNT_W-1:0] div_divisor, div_rem;

  assign in_stall = rst || (state != S_IDLE);

  assign top = (counter_top == '0) ? TOP_DEFAULT : counter_top;
  assign modv = {1'b0, top} + (CNT_W+1)'(1);
  assign half = modv[CNT_W:1];

  assign sum = {position[POS_W-1], position} + {{(POS_W+1-DABS_W){d[DABS_W-1]}}, d};
  assign dpos = {position[POS_W-1], position} - {pos_old[POS_W-1], pos_old};
  assign fdiff = {vraw[POS_W-1], vraw} - {filtered_velocity[POS_W-1], filtered_velocity};

  assign prod_shl = prod << SHL;
  assign prod_shr = prod >> F;
  assign step = acc + prod_shr[POS_W:0];

  // multiplier operands follow the stage that launches the product
  always_comb begin
    mul_a = dabs;
    mul_b = clock_hz;
    case (state)
      S_FMUL_HI: begin
        mul_a = {{(MUL_A_W-25){1'b0}}, fabs[POS_W:24]};
        mul_b = {{(MUL_B_W-F){1'b0}}, q[F-1:0]};
      end
      S_FMUL_LO: begin
        mul_a = {{(MUL_A_W-24){1'b0}}, fabs[23:0]};
        mul_b = {{(MUL_B_W-F){1'b0}}, q[F-1:0]};
      end
      default: begin
        mul_a = dabs;
        mul_b = clock_hz;
      end
    endcase
  end

  assign div_bit = (state == S_KDIV) ? 1'b0 : nlow[VEL_QBITS-1];
  assign div_divisor = (state == S_KDIV) ? lpf_tau : el_r;

  ept_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  ept_div_step u_div (
    .rem      (r),
    .bit_in   (div_bit),
    .divisor  (div_divisor),
    .rem_next (div_rem),
    .q_bit    (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      counter_top <= TOP_DEFAULT;
      invert <= 1'b0;
      clock_hz <= CLOCK_DEFAULT;
      lpf_tau <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COUNTER_TOP: counter_top <= cfg_data;
        REG_INVERT:      invert <= cfg_data[0];
        REG_CLOCK_HZ:    clock_hz <= cfg_data;
        REG_LPF_TAU:     lpf_tau <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      previous_count <= '0;
      position <= '0;
      filtered_velocity <= '0;
      current_velocity <= '0;
    end else begin
      // a result word loaded in S_DONE takes precedence over the clear
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            raw_r <= raw_count;
            el_r <= elapsed_cycles;
            if (cmd == CMD_SET_POS) begin
              position <= new_position;
              previous_count <= raw_count;
              taken <= 1'b0;
              state <= S_DONE;
            end else if (elapsed_cycles == '0) begin
              taken <= 1'b0;
              state <= S_DONE;
            end else begin
              taken <= 1'b1;
              state <= S_DELTA;
            end
          end
        end
        S_DELTA: begin
          d <= $signed({3'b000, raw_r}) - $signed({3'b000, previous_count});
          state <= S_FOLD_HI;
        end
        S_FOLD_HI: begin
          if (d > $signed({3'b000, half})) begin
            d <= d - $signed({2'b00, modv});
          end
          state <= S_FOLD_LO;
        end
        S_FOLD_LO: begin
          if (d < -$signed({3'b000, half})) begin
            d <= d + $signed({2'b00, modv});
          end
          state <= S_INV;
        end
        S_INV: begin
          if (invert) begin
            d <= -d;
          end
          state <= S_POS;
        end
        S_POS: begin
          pos_old <= position;
          previous_count <= raw_r;
          if (sum[POS_W] != sum[POS_W-1]) begin
            position <= sum[POS_W] ? NEG_MIN : POS_MAX;
          end else begin
            position <= sum[POS_W-1:0];
          end
          state <= S_DPOS;
        end
        S_DPOS: begin
          dneg <= dpos[POS_W];
          dabs <= dpos[POS_W] ? DABS_W'(-dpos) : dpos[DABS_W-1:0];
          state <= S_VMUL;
        end
        S_VMUL: begin
          state <= S_VCHK;
        end
        S_VCHK: begin
          // quotient reaches 2^47 exactly when the product from bit 31 up covers elapsed
          vsat <= (prod[MUL_P_W-1:31] >= {4'b0000, el_r});
          r <= prod[62:31];
          nlow <= {prod[30:0], {VEL_FRAC{1'b0}}};
          q <= '0;
          iter <= ITER_W'(VEL_QBITS);
          if (prod[MUL_P_W-1:31] >= {4'b0000, el_r}) begin
            state <= S_VSIGN;
          end else begin
            state <= S_VDIV;
          end
        end
        S_VDIV: begin
          r <= div_rem;
          q <= {q[VEL_QBITS-2:0], div_q};
          nlow <= {nlow[VEL_QBITS-2:0], 1'b0};
          iter <= iter - ITER_W'(1);
          if (iter == ITER_W'(1)) begin
            state <= S_VSIGN;
          end
        end
        S_VSIGN: begin
          if (dneg) begin
            vraw <= vsat ? NEG_MIN : -$signed({1'b0, q});
          end else begin
            vraw <= vsat ? POS_MAX : $signed({1'b0, q});
          end
          state <= S_FCHK;
        end
        S_FCHK: begin
          if (lpf_tau == '0) begin
            current_velocity <= vraw;
            state <= S_DONE;
          end else if (el_r >= lpf_tau) begin
            filtered_velocity <= vraw;
            current_velocity <= vraw;
            state <= S_DONE;
          end else begin
            r <= el_r;
            q <= '0;
            iter <= ITER_W'(F);
            state <= S_KDIV;
          end
        end
        S_KDIV: begin
          r <= div_rem;
          q <= {q[VEL_QBITS-2:0], div_q};
          iter <= iter - ITER_W'(1);
          if (iter == ITER_W'(1)) begin
            state <= S_FDIFF;
          end
        end
        S_FDIFF: begin
          fneg <= fdiff[POS_W];
          fabs <= fdiff[POS_W] ? (POS_W+1)'(-fdiff) : fdiff;
          state <= S_FMUL_HI;
        end
        S_FMUL_HI: begin
          state <= S_FMUL_LO;
        end
        S_FMUL_LO: begin
          acc <= prod_shl[POS_W:0];
          state <= S_FSUM;
        end
        S_FSUM: begin
          if (fneg) begin
            filtered_velocity <= filtered_velocity - $signed(step[POS_W-1:0]);
            current_velocity <= filtered_velocity - $signed(step[POS_W-1:0]);
          end else begin
            filtered_velocity <= filtered_velocity + $signed(step[POS_W-1:0]);
            current_velocity <= filtered_velocity + $signed(step[POS_W-1:0]);
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            position_counts <= position;
            velocity_cps <= current_velocity;
            sample_taken <= taken;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/ept_checker.sv
module ept_checker
  import ept_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [POS_W-1:0] position_counts,
  input logic signed [POS_W-1:0] velocity_cps,
  input logic                    sample_taken
);

  // an accepted word leaves the block busy in the following cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after accept");

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word valid after reset");

  // idle with nothing pending cannot produce a result in the next cycle
  a_no_spurious_out: assert property (@(posedge clk) disable iff (rst)
    !in_stall && !out_valid |=> !out_valid)
    else $error("result word without a word in work");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(position_counts)
      && $stable(velocity_cps) && $stable(sample_taken))
    else $error("stalled result word changed");

endmodule

bind encoder_position_velocity_tracker_unit ept_checker u_ept_checker (.*);
